/* hw/rtl/sdoc_pkg.sv */
// Shared types, codes and constants of the expedited SDO client.
`timescale 1ns / 1ps
package sdoc_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FRAME = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PARAM      = 3'd1,
    ST_TIMEOUT    = 3'd2,
    ST_ABORT      = 3'd3,
    ST_UNEXPECTED = 3'd4
  } status_t;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_DONE  = 1'b1
  } kind_t;

  localparam logic [10:0] SDO_RX_BASE     = 11'h600;
  localparam logic [10:0] SDO_TX_BASE     = 11'h580;
  localparam logic [7:0]  CMD_UPLOAD_REQ  = 8'h40;
  localparam logic [7:0]  CMD_DOWNLOAD_OK = 8'h60;
  localparam logic [7:0]  CMD_ABORT       = 8'h80;
  localparam logic [7:0]  CMD_CLASS_MASK  = 8'hE0;
  localparam logic [7:0]  CMD_DL_1        = 8'h2F;
  localparam logic [7:0]  CMD_DL_2        = 8'h2B;
  localparam logic [7:0]  CMD_DL_3        = 8'h27;
  localparam logic [7:0]  CMD_DL_4        = 8'h23;
  localparam logic [7:0]  NODE_MAX        = 8'd127;

  // Depth of the result queue; a power of two so that its pointers wrap on their own.
  localparam int unsigned RESQ_DEPTH = 4;

  typedef struct packed {
    action_t      action;
    logic [7:0]   node;
    logic [15:0]  od_index;
    logic [7:0]   od_subindex;
    logic [31:0]  write_value;
    logic [2:0]   write_size;
    logic [15:0]  timeout_ticks;
    logic [10:0]  rx_id;
    logic [63:0]  rx_data;
  } item_t;

  typedef struct packed {
    kind_t        kind;
    logic [10:0]  tx_id;
    logic [63:0]  tx_data;
    status_t      status;
    logic [31:0]  read_value;
  } result_t;

  // Download command byte for a given size; zero marks an illegal size.
  function automatic logic [7:0] size_command(input logic [2:0] size);
    logic [7:0] cmd;
    unique case (size)
      3'd1:    cmd = CMD_DL_1;
      3'd2:    cmd = CMD_DL_2;
      3'd3:    cmd = CMD_DL_3;
      3'd4:    cmd = CMD_DL_4;
      default: cmd = 8'h00;
    endcase
    return cmd;
  endfunction

endpackage

/* hw/rtl/sdoc_core.sv */
// Transfer state and the decode of one item into up to two results.
`timescale 1ns / 1ps
module sdoc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sdoc_pkg::item_t   item,
  output logic [1:0]        res_cnt,
  output sdoc_pkg::result_t res0,
  output sdoc_pkg::result_t res1
);
  import sdoc_pkg::*;

  logic        waiting_r, waiting_nxt;
  logic        is_read_r, is_read_nxt;
  logic [6:0]  peer_node_r, peer_node_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [15:0] limit_r, limit_nxt;

  logic        rd;
  logic [7:0]  cmd;
  logic        req_ok;
  logic [7:0]  b0;
  logic [63:0] frame;

  always_comb begin
    rd      = (item.action == ACT_READ);
    cmd     = rd ? CMD_UPLOAD_REQ : size_command(item.write_size);
    req_ok  = (item.node != 8'd0) && (item.node <= NODE_MAX) && (cmd != 8'h00);
    b0      = item.rx_data[7:0];
    frame   = {rd ? 32'd0 : item.write_value, item.od_subindex, item.od_index, cmd};
  end

  always_comb begin
    waiting_nxt   = waiting_r;
    is_read_nxt   = is_read_r;
    peer_node_nxt = peer_node_r;
    elapsed_nxt   = elapsed_r;
    limit_nxt     = limit_r;
    res_cnt       = 2'd0;
    res0          = '0;
    res1          = '0;
    res0.kind     = KIND_DONE;
    res1.kind     = KIND_DONE;
    unique case (item.action)
      ACT_WRITE, ACT_READ: begin
        if (!waiting_r) begin
          res_cnt = 2'd1;
          if (!req_ok) begin
            res0.status = ST_PARAM;
          end else begin
            res0.kind    = KIND_FRAME;
            res0.tx_id   = SDO_RX_BASE + {3'b000, item.node};
            res0.tx_data = frame;
            if (item.timeout_ticks == 16'd0) begin
              res_cnt     = 2'd2;
              res1.status = ST_TIMEOUT;
            end else begin
              waiting_nxt   = 1'b1;
              is_read_nxt   = rd;
              peer_node_nxt = item.node[6:0];
              elapsed_nxt   = 16'd0;
              limit_nxt     = item.timeout_ticks;
            end
          end
        end
      end
      ACT_FRAME: begin
        if (waiting_r && (item.rx_id == SDO_TX_BASE + {4'b0000, peer_node_r})) begin
          waiting_nxt = 1'b0;
          res_cnt     = 2'd1;
          if (b0 == CMD_ABORT) begin
            res0.status = ST_ABORT;
          end else if (!is_read_r) begin
            res0.status = (b0 == CMD_DOWNLOAD_OK) ? ST_OK : ST_UNEXPECTED;
          end else if ((b0 & CMD_CLASS_MASK) != CMD_UPLOAD_REQ) begin
            res0.status = ST_UNEXPECTED;
          end else begin
            res0.status     = ST_OK;
            res0.read_value = item.rx_data[63:32];
          end
        end
      end
      ACT_TICK: begin
        if (waiting_r) begin
          // The counter saturates so a long wait never wraps around.
          elapsed_nxt = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
          if (elapsed_nxt >= limit_r) begin
            waiting_nxt = 1'b0;
            res_cnt     = 2'd1;
            res0.status = ST_TIMEOUT;
          end
        end
      end
      default: begin
        res_cnt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r   <= 1'b0;
      is_read_r   <= 1'b0;
      peer_node_r <= 7'd0;
      elapsed_r   <= 16'd0;
      limit_r     <= 16'd0;
    end else if (fire) begin
      waiting_r   <= waiting_nxt;
      is_read_r   <= is_read_nxt;
      peer_node_r <= peer_node_nxt;
      elapsed_r   <= elapsed_nxt;
      limit_r     <= limit_nxt;
    end
  end

endmodule

/* hw/rtl/sdoc_resq.sv */
// Small result queue that takes up to two results per cycle and hands out one while not stalled.
`timescale 1ns / 1ps
module sdoc_resq #(
  parameter int unsigned DEPTH = sdoc_pkg::RESQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  sdoc_pkg::result_t push0,
  input  sdoc_pkg::result_t push1,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_stall,
  output sdoc_pkg::result_t head
);
  import sdoc_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  result_t       mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;
  logic [PW-1:0] wr_ptr_p1;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count_r != '0);
  assign head      = mem[rd_ptr_r];
  // Room for the largest burst one item can cause.
  assign room2     = (count_r <= CW'(DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + PW'(1);

  always_comb begin
    count_nxt = count_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PW'(push_cnt);
      rd_ptr_r <= rd_ptr_r + PW'(pop);
      count_r  <= count_nxt;
    end
  end

endmodule

/* hw/rtl/sdo_expedited_client.sv */
// Top level of the expedited SDO client: input register, decode core, result queue.
//
//   Channel  Direction  Handshake          Moves
//   in_*     input      in_valid/in_stall  one request, received frame or tick
//   out_*    output     out_valid/out_stall one request frame or one completion
//
// An item is taken into the input register and decoded from there; while the queue
// has room, its results (none, one or two) enter a four-entry result queue. The block
// takes one item per cycle; it stalls the input only while the queue lacks room
// for two results. A queued result is shown for transfer once it reaches the head.
// Reset (rst_n low at a clock edge) returns the client to idle and empties the queue.
// A stalled output holds its result; results leave in the order they were made.
`timescale 1ns / 1ps
module sdo_expedited_client #(
  parameter int unsigned RESQ_DEPTH = sdoc_pkg::RESQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_node,
  input  logic [15:0] in_od_index,
  input  logic [7:0]  in_od_subindex,
  input  logic [31:0] in_write_value,
  input  logic [2:0]  in_write_size,
  input  logic [15:0] in_timeout_ticks,
  input  logic [10:0] in_rx_id,
  input  logic [63:0] in_rx_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [10:0] out_tx_id,
  output logic [63:0] out_tx_data,
  output logic [2:0]  out_status,
  output logic [31:0] out_read_value
);
  import sdoc_pkg::*;

  // Input register stage.
  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    q_room;
  logic    advance;

  logic [1:0] res_cnt;
  result_t    res0, res1;
  result_t    head;

  // The registered item moves on when the queue can absorb a two-result burst.
  assign advance  = s1_valid_r && q_room;
  assign in_stall = s1_valid_r && !q_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  // Payload needs no reset; it is only loaded on a transfer.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= '{action:        action_t'(in_action),
                     node:          in_node,
                     od_index:      in_od_index,
                     od_subindex:   in_od_subindex,
                     write_value:   in_write_value,
                     write_size:    in_write_size,
                     timeout_ticks: in_timeout_ticks,
                     rx_id:         in_rx_id,
                     rx_data:       in_rx_data};
    end
  end

  sdoc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .item    (s1_item_r),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  sdoc_resq #(
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (advance ? res_cnt : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .room2     (q_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_kind       = head.kind;
  assign out_tx_id      = head.tx_id;
  assign out_tx_data    = head.tx_data;
  assign out_status     = head.status;
  assign out_read_value = head.read_value;

endmodule

/* hw/rtl/sdoc_checker.sv */
// Port-level checks of the expedited SDO client and their binding to the top level.
`timescale 1ns / 1ps
module sdoc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [10:0] out_tx_id,
  input logic [63:0] out_tx_data,
  input logic [2:0]  out_status,
  input logic [31:0] out_read_value
);
  import sdoc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  a_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_FRAME) |-> (out_status == 3'd0) && (out_read_value == 32'd0))
    else $error("request frame carries completion fields");

  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DONE) |-> (out_tx_id == 11'd0) && (out_tx_data == 64'd0))
    else $error("completion carries frame fields");

  a_frame_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_FRAME) |-> (out_tx_id[10:7] == 4'hC) && (out_tx_id[6:0] != 7'd0))
    else $error("request frame identifier outside the client range");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DONE) |-> (out_status <= 3'd4))
    else $error("completion status out of range");

endmodule

bind sdo_expedited_client sdoc_checker u_sdoc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_tx_id      (out_tx_id),
  .out_tx_data    (out_tx_data),
  .out_status     (out_status),
  .out_read_value (out_read_value)
);
